// File: hdl/masked_byte_pattern_search_core_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the masked byte pattern search core
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SEARCH_CORE_MACROS_SVH
`define MASKED_BYTE_PATTERN_SEARCH_CORE_MACROS_SVH

`ifndef SYNTH

`define MBPS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MBPS_ASSERT_IMPLY(label, ante, cons, msg)

`define MBPS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hdl/mbps_pkg.sv
// -----------------------------------------------------------------------------
// Masked byte pattern search package
// Shared widths, register indexes and the result record.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbps_pkg;

  localparam int MaxPatternDefault = 16;
  localparam int PatternBytes      = 16;

  localparam int AddrW   = 64;
  localparam int DataW   = 8;
  localparam int MaskW   = 16;
  localparam int LenW    = 5;
  localparam int LimitW  = 16;
  localparam int PosW    = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 64;

  localparam logic [CfgIdxW-1:0] CfgPatternLow  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPatternHigh = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCareMask    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPatternLen  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBaseAddress = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgHitLimit    = 3'd5;

  typedef struct packed {
    logic [AddrW-1:0] match_address;
    logic             is_match;
    logic             end_of_buffer;
  } mbps_result_t;

endpackage

// File: hdl/mbps_matcher.sv
// -----------------------------------------------------------------------------
// Masked byte pattern search matcher
// Holds the configuration, the byte window and the run counters, and forms
// the result of each accepted beat in the same cycle.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbps_matcher #(
  parameter int MAX_PATTERN = mbps_pkg::MaxPatternDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mbps_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [mbps_pkg::CfgW-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [mbps_pkg::DataW-1:0]          in_byte_i,
  input  logic                                in_last_i,
  output logic                                res_valid_o,
  output mbps_pkg::mbps_result_t              res_o
);
  import mbps_pkg::*;

  localparam int UsedMax = (MAX_PATTERN < PatternBytes) ? MAX_PATTERN : PatternBytes;
  localparam int IdxW    = (UsedMax > 1) ? $clog2(UsedMax) : 1;
  localparam int FillW   = $clog2(UsedMax + 1);

  logic [AddrW-1:0]  pat_lo_q, pat_hi_q, base_q;
  logic [MaskW-1:0]  mask_q;
  logic [LenW-1:0]   len_cfg_q;
  logic [LimitW-1:0] limit_q;

  logic [DataW-1:0]  window_q [UsedMax];
  logic [DataW-1:0]  window_d [UsedMax];
  logic [DataW-1:0]  win_new  [UsedMax];
  logic [FillW-1:0]  fill_q, fill_d, fill_new;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [LimitW-1:0] hits_q, hits_d;

  logic [DataW-1:0]  pat_bytes [PatternBytes];
  logic [LenW-1:0]   len;
  logic [LimitW-1:0] limit;
  logic [UsedMax-1:0] byte_ok;
  logic [LenW-1:0]   widx [UsedMax];
  logic              accept, match, report;
  logic [PosW-1:0]   start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      mask_q    <= '1;
      len_cfg_q <= '0;
      base_q    <= '0;
      limit_q   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPatternLow:  pat_lo_q  <= cfg_data_i;
        CfgPatternHigh: pat_hi_q  <= cfg_data_i;
        CfgCareMask:    mask_q    <= cfg_data_i[MaskW-1:0];
        CfgPatternLen:  len_cfg_q <= cfg_data_i[LenW-1:0];
        CfgBaseAddress: base_q    <= cfg_data_i;
        CfgHitLimit:    limit_q   <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_i;
  assign len    = (len_cfg_q > LenW'(UsedMax)) ? LenW'(UsedMax) : len_cfg_q;
  assign limit  = (limit_q == '0) ? LimitW'(1) : limit_q;

  always_comb begin
    for (int i = 0; i < PatternBytes / 2; i++) begin
      pat_bytes[i]                    = pat_lo_q[i*DataW +: DataW];
      pat_bytes[i + PatternBytes / 2] = pat_hi_q[i*DataW +: DataW];
    end
  end

  always_comb begin
    win_new[0] = in_byte_i;
    for (int i = 1; i < UsedMax; i++) begin
      win_new[i] = window_q[i-1];
    end
  end

  assign fill_new = (fill_q == FillW'(UsedMax)) ? fill_q : fill_q + FillW'(1);

  // The newest byte closes the candidate, so pattern byte k sits len-1-k back.
  always_comb begin
    for (int k = 0; k < UsedMax; k++) begin
      widx[k]    = len - LenW'(1) - LenW'(k);
      byte_ok[k] = (LenW'(k) >= len) || !mask_q[k] ||
                   (win_new[widx[k][IdxW-1:0]] == pat_bytes[k]);
    end
  end

  assign match  = (len != '0) && (LenW'(fill_new) >= len) && (&byte_ok);
  assign report = accept && (hits_q < limit) && match;
  assign start  = pos_q - PosW'(len) + PosW'(1);

  assign res_valid_o          = accept && (report || in_last_i);
  assign res_o.match_address  = report ? (base_q + {{(AddrW-PosW){1'b0}}, start}) : '0;
  assign res_o.is_match       = report;
  assign res_o.end_of_buffer  = in_last_i;

  always_comb begin
    window_d = window_q;
    fill_d   = fill_q;
    pos_d    = pos_q;
    hits_d   = hits_q;
    if (accept) begin
      if (in_last_i) begin
        for (int i = 0; i < UsedMax; i++) begin
          window_d[i] = '0;
        end
        fill_d = '0;
        pos_d  = '0;
        hits_d = '0;
      end else begin
        window_d = win_new;
        fill_d   = fill_new;
        pos_d    = pos_q + PosW'(1);
        hits_d   = hits_q + LimitW'(report);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < UsedMax; i++) begin
        window_q[i] <= '0;
      end
      fill_q <= '0;
      pos_q  <= '0;
      hits_q <= '0;
    end else begin
      window_q <= window_d;
      fill_q   <= fill_d;
      pos_q    <= pos_d;
      hits_q   <= hits_d;
    end
  end

endmodule

// File: hdl/mbps_out_buf.sv
// -----------------------------------------------------------------------------
// Masked byte pattern search output buffer
// Result register with a skid entry, so a beat is taken while a result waits.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbps_out_buf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  mbps_pkg::mbps_result_t push_data_i,
  output logic                   space_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output mbps_pkg::mbps_result_t out_data_o
);
  import mbps_pkg::*;

  logic         out_valid_q, skid_valid_q;
  mbps_result_t out_q, skid_q;
  logic         pop;

  assign pop         = out_valid_q && out_ready_i;
  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_q <= push_data_i;
      end else begin
        out_q <= push_data_i;
      end
    end
  end

endmodule

// File: hdl/masked_byte_pattern_search_core.sv
// -----------------------------------------------------------------------------
// Masked byte pattern search core
// Output: each result is registered in the output buffer, or in its skid entry, before the master side.
// Throughput: one byte per cycle while the skid entry is free; all pattern bytes are compared in parallel
// against the shift window, and the skid entry holds a result that arrives while the output is stalled.
// Reset: rst_ni clears the window and counters and restores register defaults.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "masked_byte_pattern_search_core_macros.svh"

module masked_byte_pattern_search_core #(
  parameter int MAX_PATTERN = mbps_pkg::MaxPatternDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mbps_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // data_byte [7:0]
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [63:0]                   m_axis_tdata_o,  // match_address [63:0]
  output logic                          m_axis_tuser_o,  // is_match [0]
  output logic                          m_axis_tlast_o
);
  import mbps_pkg::*;

  logic         res_valid, space;
  mbps_result_t res, out_data;

  assign s_axis_tready_o = space;

  mbps_matcher #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_matcher (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_i  (space),
    .in_byte_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mbps_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata_o = out_data.match_address;
  assign m_axis_tuser_o = out_data.is_match;
  assign m_axis_tlast_o = out_data.end_of_buffer;

  `MBPS_ASSERT_IMPLY(a_full_implies_out_valid, !s_axis_tready_o, m_axis_tvalid_o, "skid full with empty output")
  `MBPS_ASSERT_IMPLY(a_nonmatch_is_end, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tlast_o && (m_axis_tdata_o == '0), "result without match must be end of buffer with zero address")
  `MBPS_ASSERT_NEXT(a_stall_fills_skid, m_axis_tvalid_o && !m_axis_tready_i && s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, !s_axis_tready_o, "stalled end beat not held in skid entry")

endmodule
